[hw/rtl/bcbe_pkg.sv]
package bcbe_pkg;

  localparam int unsigned NodeIntervals = 4;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned AccW          = 41;
  localparam int unsigned NodeW         = 50;

  localparam logic [1:0] RegScale  = 2'd0;
  localparam logic [1:0] RegOffset = 2'd1;
  localparam logic [1:0] RegIndex  = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StNode,
    StTerm,
    StFinal,
    StDiv,
    StOut
  } state_e;

  // Request for one division, and the quotient that comes back.
  typedef struct packed {
    logic              start;
    logic [63:0]       dividend;
    logic [63:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [63:0]       quotient;
  } div_rsp_t;

  // Cosine of j*pi/N, 13-term integer Taylor series in Q2.30, rounded to fb frac bits, elaborated as constant.
  function automatic logic signed [31:0] cos_rom(input int unsigned j, input int unsigned n,
                                                 input int unsigned fb);
    logic          neg;
    logic [63:0]   a;
    logic [127:0]  t;
    longint        c;
    int unsigned   jj;
    neg = 1'b0;
    jj  = j;
    if (2 * jj > n) begin
      jj  = n - jj;
      neg = 1'b1;
    end
    a = (64'd3373259425 * 64'(jj)) / 64'(n);
    t = 128'd1 << 30;
    c = longint'(t);
    for (int i = 1; i <= 12; i++) begin
      t = (t * 128'(a)) >> 30;
      t = (t * 128'(a)) >> 30;
      t = t / 128'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) c = c - longint'(t[63:0]);
      else            c = c + longint'(t[63:0]);
    end
    if (c < 0) c = 0;
    c = (c + (longint'(1) << (29 - fb))) >>> (30 - fb);
    return neg ? 32'(-c) : 32'(c);
  endfunction

endpackage

[hw/rtl/bcbe_div.sv]
// Restoring divider on magnitudes, one quotient bit per cycle.
module bcbe_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcbe_pkg::div_req_t  req_i,
  output bcbe_pkg::div_rsp_t  rsp_o
);

  logic [63:0] quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[63]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[hw/rtl/bcbe_cell.sv]
// One node of the chain: holds its node position and passes it to the neighbour on shift.
module bcbe_cell #(
  parameter int unsigned NodeW = bcbe_pkg::NodeW
) (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  logic                    shift_i,
  input  logic signed [NodeW-1:0] load_val_i,
  input  logic signed [NodeW-1:0] prev_i,
  output logic signed [NodeW-1:0] node_o
);

  logic signed [NodeW-1:0] node_q, node_d;

  always_comb begin
    node_d = node_q;
    if (load_i)       node_d = load_val_i;
    else if (shift_i) node_d = prev_i;
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
  end

  assign node_o = node_q;

endmodule

[hw/rtl/barycentric_chebyshev_basis_eval.sv]
// Flow (N = NODE_INTERVALS): the N+1 nodes are loaded into the node chain, then each term
// is divided on the shared 64-step divider and then the ratio on the same divider;
// a zero sum skips the ratio division.
// A request on a node or with an index above N skips all divisions.
// One request at a time: a new one is taken the cycle after the result leaves.
// Reset clears the controller and restores node_scale 65536, node_offset 0, basis_index 0.
module barycentric_chebyshev_basis_eval #(
  parameter int unsigned NODE_INTERVALS = bcbe_pkg::NodeIntervals,
  parameter int unsigned FRAC_BITS      = bcbe_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] x_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] basis_value_o,
  output logic               saturated_o,
  output logic               at_node_o
);

  localparam int unsigned NN    = NODE_INTERVALS + 1;
  localparam int unsigned IdxW  = $clog2(NN + 1);
  localparam int unsigned NodeW = bcbe_pkg::NodeW;
  localparam int unsigned AccW  = bcbe_pkg::AccW;
  localparam logic signed [AccW-1:0] AccMax = AccW'((64'sd1 <<< 39) - 1);
  localparam logic signed [AccW-1:0] AccMin = -AccMax;
  localparam logic [63:0] OneSq = 64'd1 << (2 * FRAC_BITS);

  typedef logic signed [31:0] cos_arr_t [NN];

  function automatic cos_arr_t build_cos();
    cos_arr_t r;
    for (int i = 0; i < NN; i++) begin
      r[i] = bcbe_pkg::cos_rom(NODE_INTERVALS - i, NODE_INTERVALS, FRAC_BITS);
    end
    return r;
  endfunction

  localparam cos_arr_t CosTab = build_cos();

  // Configuration registers
  logic [22:0]        scale_q;
  logic signed [23:0] offset_q;
  logic [4:0]         bidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 23'd65536;
      offset_q <= '0;
      bidx_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bcbe_pkg::RegScale:  scale_q  <= cfg_data_i[22:0];
        bcbe_pkg::RegOffset: offset_q <= cfg_data_i;
        bcbe_pkg::RegIndex:  bidx_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  bcbe_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]    cnt_q, cnt_d;
  logic signed [23:0] x_q;
  logic signed [AccW-1:0] den_q, den_d, num_q, num_d;
  logic sat_q, sat_d, hit_q, hit_d, hitm_q, hitm_d, qneg_q, qneg_d;
  logic signed [23:0] res_q, res_d;

  // Node generation: one node per cycle, entered at the chain head.
  logic signed [25:0]  csum;
  logic signed [49:0]  prod;
  logic signed [NodeW-1:0] node_new;
  assign csum     = 26'(CosTab[cnt_q[IdxW-1:0] < IdxW'(NN) ? cnt_q : '0])
                  + 26'(offset_q);
  assign prod     = csum * $signed({1'b0, scale_q});
  assign node_new = prod >>> FRAC_BITS;

  logic shift_en;
  logic signed [NodeW-1:0] chain [NN];

  for (genvar g = 0; g < NN; g++) begin : g_cell
    bcbe_cell #(.NodeW(NodeW)) u_cell (
      .clk_i      (clk_i),
      .load_i     (1'b0),
      .shift_i    (shift_en),
      .load_val_i ('0),
      .prev_i     (g == 0 ? node_new : chain[(g == 0) ? 0 : g - 1]),
      .node_o     (chain[g])
    );
  end

  // The chain tail holds the current node; each finished term shifts a fresh node in at the head.
  logic signed [NodeW-1:0] tail;
  assign tail = chain[NN-1];

  bcbe_pkg::div_req_t dreq;
  bcbe_pkg::div_rsp_t drsp;

  bcbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  logic signed [NodeW:0] diff;
  logic [NodeW:0]        diff_mag;
  logic                  tneg;
  logic signed [65:0]    tval;
  logic signed [AccW-1:0] tclip, sum_clip;
  logic signed [AccW:0]   sum;
  logic                   t_sat, s_sat;
  logic [IdxW-1:0]        term_idx;
  logic signed [65:0]     qval;

  assign diff     = $signed({x_q[23], x_q}) - (NodeW+1)'(tail);
  assign diff_mag = diff[NodeW] ? (NodeW+1)'(-diff) : diff;
  assign term_idx = cnt_q;

  always_comb begin
    tneg  = diff[NodeW] ^ term_idx[0];
    tval  = tneg ? -$signed({2'b0, drsp.quotient}) : $signed({2'b0, drsp.quotient});
    t_sat = 1'b0;
    if (tval > 66'(AccMax))      begin tclip = AccMax; t_sat = 1'b1; end
    else if (tval < 66'(AccMin)) begin tclip = AccMin; t_sat = 1'b1; end
    else                           tclip = AccW'(tval);
    sum   = (AccW+1)'(den_q) + (AccW+1)'(tclip);
    s_sat = 1'b0;
    if (sum > (AccW+1)'(AccMax))      begin sum_clip = AccMax; s_sat = 1'b1; end
    else if (sum < (AccW+1)'(AccMin)) begin sum_clip = AccMin; s_sat = 1'b1; end
    else                                sum_clip = AccW'(sum);
    qval = qneg_q ? -$signed({2'b0, drsp.quotient}) : $signed({2'b0, drsp.quotient});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcbe_pkg::StIdle:  if (in_valid_i) state_d = bcbe_pkg::StNode;
      bcbe_pkg::StNode:  if (cnt_q == IdxW'(NN - 1)) state_d = bcbe_pkg::StTerm;
      bcbe_pkg::StTerm: begin
        if (hit_q || bidx_q > 5'(NODE_INTERVALS)) state_d = bcbe_pkg::StOut;
        else if (drsp.done && cnt_q == IdxW'(NN - 1)) state_d = bcbe_pkg::StFinal;
      end
      bcbe_pkg::StFinal: state_d = (den_q == '0) ? bcbe_pkg::StOut : bcbe_pkg::StDiv;
      bcbe_pkg::StDiv:   if (drsp.done) state_d = bcbe_pkg::StOut;
      bcbe_pkg::StOut:   if (!out_stall_i) state_d = bcbe_pkg::StIdle;
      default:           state_d = bcbe_pkg::StIdle;
    endcase
  end

  logic term_started_q, term_started_d;

  always_comb begin
    cnt_d      = cnt_q;
    den_d      = den_q;
    num_d      = num_q;
    sat_d      = sat_q;
    hit_d      = hit_q;
    hitm_d     = hitm_q;
    qneg_d     = qneg_q;
    res_d      = res_q;
    term_started_d = term_started_q;
    shift_en   = 1'b0;
    dreq       = '0;
    unique case (state_q)
      bcbe_pkg::StIdle: begin
        cnt_d  = '0;
        den_d  = '0;
        num_d  = '0;
        sat_d  = 1'b0;
        hit_d  = 1'b0;
        hitm_d = 1'b0;
        term_started_d = 1'b0;
      end
      bcbe_pkg::StNode: begin
        shift_en = 1'b1;
        if ((NodeW+1)'(node_new) == (NodeW+1)'($signed(x_q))) begin
          hit_d = 1'b1;
          if (5'(cnt_q) == bidx_q) hitm_d = 1'b1;
        end
        cnt_d = (cnt_q == IdxW'(NN - 1)) ? '0 : cnt_q + 1'b1;
      end
      bcbe_pkg::StTerm: begin
        // No division is started when the answer is already known.
        if (!term_started_q && !hit_q && bidx_q <= 5'(NODE_INTERVALS)) begin
          dreq.start    = 1'b1;
          dreq.dividend = (cnt_q == '0 || cnt_q == IdxW'(NODE_INTERVALS)) ? OneSq >> 1 : OneSq;
          dreq.divisor  = 64'(diff_mag);
          term_started_d = 1'b1;
        end else if (term_started_q && drsp.done) begin
          sat_d = sat_q | t_sat | s_sat;
          den_d = sum_clip;
          if (5'(cnt_q) == bidx_q) num_d = tclip;
          shift_en = 1'b1;
          term_started_d = 1'b0;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      bcbe_pkg::StFinal: begin
        qneg_d = num_q[AccW-1] ^ den_q[AccW-1];
        if (den_q == '0) begin
          if (num_q != '0) begin
            sat_d = 1'b1;
            res_d = num_q[AccW-1] ? 24'sh800000 : 24'sh7fffff;
          end else begin
            res_d = '0;
          end
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = 64'(num_q[AccW-1] ? -num_q : num_q) << FRAC_BITS;
          dreq.divisor  = 64'(den_q[AccW-1] ? -den_q : den_q);
        end
      end
      bcbe_pkg::StDiv: begin
        if (drsp.done) begin
          if (qval > 66'sd8388607)       begin res_d = 24'sh7fffff; sat_d = 1'b1; end
          else if (qval < -66'sd8388608) begin res_d = 24'sh800000; sat_d = 1'b1; end
          else                             res_d = qval[23:0];
        end
      end
      bcbe_pkg::StOut: begin
        if (hit_q) begin
          res_d = hitm_q ? 24'(1 << FRAC_BITS) : '0;
          if (hitm_q && FRAC_BITS > 22) sat_d = 1'b1;
          if (hitm_q && FRAC_BITS > 22) res_d = 24'sh7fffff;
          hit_d = hit_q;
        end else if (bidx_q > 5'(NODE_INTERVALS)) begin
          res_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bcbe_pkg::StIdle;
      cnt_q          <= '0;
      term_started_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      term_started_q <= term_started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bcbe_pkg::StIdle && in_valid_i) x_q <= x_value_i;
    den_q      <= den_d;
    num_q      <= num_d;
    sat_q      <= sat_d;
    hit_q      <= hit_d;
    hitm_q     <= hitm_d;
    qneg_q     <= qneg_d;
    res_q      <= res_d;
  end

  assign in_stall_o    = (state_q != bcbe_pkg::StIdle);
  assign out_valid_o   = (state_q == bcbe_pkg::StOut);
  assign basis_value_o = hit_q ? (hitm_q ? ((FRAC_BITS > 22) ? 24'sh7fffff
                                                             : 24'(1 << FRAC_BITS)) : '0)
                               : ((bidx_q > 5'(NODE_INTERVALS)) ? '0 : res_q);
  assign saturated_o   = hit_q ? (hitm_q && FRAC_BITS > 22)
                               : ((bidx_q > 5'(NODE_INTERVALS)) ? 1'b0 : sat_q);
  assign at_node_o     = hit_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_div_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (state_q == bcbe_pkg::StTerm || state_q == bcbe_pkg::StDiv))
    else $error("stray divider completion");

endmodule
